// ----- src/satq_pkg.sv -----
// Shared types, codes and constants of the sorted alarm timer queue.
package satq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned TIME_BITS   = 48;
  localparam int unsigned TAG_BITS    = 16;
  localparam int unsigned DELAY_BITS  = 32;
  localparam int unsigned CSLOT_BITS  = 4;
  localparam int unsigned SLOT_OUT_W  = 4;
  localparam int unsigned LATE_BITS   = 31;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned NRES_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_CANCEL = 2'd2;

  localparam logic [2:0] KIND_ADDED  = 3'd0;
  localparam logic [2:0] KIND_FULL   = 3'd1;
  localparam logic [2:0] KIND_FIRED  = 3'd2;
  localparam logic [2:0] KIND_NONE   = 3'd3;
  localparam logic [2:0] KIND_CANCEL = 3'd4;

  typedef struct packed {
    logic [1:0]                   req_type;
    logic [TIME_BITS-1:0]         now_ms;
    logic signed [DELAY_BITS-1:0] offset_ms;
    logic [TAG_BITS-1:0]          tag;
    logic [CSLOT_BITS-1:0]        cancel_slot;
  } satq_req_t;

  typedef struct packed {
    logic [2:0]            kind;
    logic [SLOT_OUT_W-1:0] slot;
    logic [TAG_BITS-1:0]   fired_tag;
    logic [LATE_BITS-1:0]  lateness_ms;
    logic                  last;
  } satq_res_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FREE_STEP,
    OP_WALK_INIT,
    OP_ORD_READ,
    OP_DL_READ,
    OP_WALK_CMP,
    OP_PLACE,
    OP_CANCEL,
    OP_HEAD_READ,
    OP_TICK_EVAL,
    OP_EMIT
  } satq_op_e;

  typedef enum logic [1:0] {
    SEL_ADDED,
    SEL_FULL,
    SEL_CANCEL,
    SEL_TICK_END
  } satq_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FREE,
    ST_WINIT,
    ST_WORD,
    ST_WDL,
    ST_WCMP,
    ST_PLACE,
    ST_CANCEL,
    ST_TCHK,
    ST_TDL,
    ST_TEVAL,
    ST_EMIT
  } satq_state_e;

  typedef struct packed {
    satq_op_e  op;
    satq_sel_e sel;
  } satq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic free_hit;
    logic walk_move;
    logic walk_first;
    logic res_limit;
    logic head_del;
    logic head_due;
    logic pend_valid;
    logic out_free;
  } satq_status_t;

endpackage

// ----- src/satq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module satq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/satq_ctrl.sv -----
// Controller state machine sequencing add, tick and cancel requests.
module satq_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             req_type_i,
  input  satq_pkg::satq_status_t status_i,
  output logic                   in_stall_o,
  output satq_pkg::satq_cmd_t    cmd_o
);
  import satq_pkg::*;

  satq_state_e state_q, state_d;
  satq_sel_e   sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= SEL_ADDED;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    sel_d     = sel_q;
    cmd_o.op  = OP_NONE;
    cmd_o.sel = sel_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          case (req_type_i)
            REQ_ADD: begin
              if (status_i.full) begin
                sel_d   = SEL_FULL;
                state_d = ST_EMIT;
              end else begin
                state_d = ST_FREE;
              end
            end
            REQ_TICK:   state_d = ST_TCHK;
            REQ_CANCEL: state_d = ST_CANCEL;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_FREE: begin
        cmd_o.op = OP_FREE_STEP;
        if (status_i.free_hit) begin
          state_d = ST_WINIT;
        end
      end
      ST_WINIT: begin
        cmd_o.op = OP_WALK_INIT;
        state_d  = status_i.empty ? ST_PLACE : ST_WORD;
      end
      ST_WORD: begin
        cmd_o.op = OP_ORD_READ;
        state_d  = ST_WDL;
      end
      ST_WDL: begin
        cmd_o.op = OP_DL_READ;
        state_d  = ST_WCMP;
      end
      ST_WCMP: begin
        cmd_o.op = OP_WALK_CMP;
        if (status_i.walk_move && !status_i.walk_first) begin
          state_d = ST_WORD;
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd_o.op = OP_PLACE;
        sel_d    = SEL_ADDED;
        state_d  = ST_EMIT;
      end
      ST_CANCEL: begin
        cmd_o.op = OP_CANCEL;
        sel_d    = SEL_CANCEL;
        state_d  = ST_EMIT;
      end
      ST_TCHK: begin
        if (status_i.empty || status_i.res_limit) begin
          sel_d   = SEL_TICK_END;
          state_d = ST_EMIT;
        end else begin
          cmd_o.op = OP_HEAD_READ;
          state_d  = ST_TDL;
        end
      end
      ST_TDL: begin
        cmd_o.op = OP_DL_READ;
        state_d  = ST_TEVAL;
      end
      ST_TEVAL: begin
        cmd_o.op = OP_TICK_EVAL;
        if (status_i.head_del) begin
          state_d = ST_TCHK;
        end else if (!status_i.head_due) begin
          sel_d   = SEL_TICK_END;
          state_d = ST_EMIT;
        end else if (status_i.pend_valid && !status_i.out_free) begin
          state_d = ST_TEVAL;
        end else begin
          state_d = ST_TCHK;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ----- src/satq_dp.sv -----
// Datapath: slot storage, circular order list, walk registers and result register.
module satq_dp #(
  parameter int unsigned QUEUE_DEPTH = satq_pkg::QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  satq_pkg::satq_req_t    in_req_i,
  input  satq_pkg::satq_cmd_t    cmd_i,
  output satq_pkg::satq_status_t status_o,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output satq_pkg::satq_res_t    out_res_o
);
  import satq_pkg::*;

  localparam int unsigned SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DL_W   = TIME_BITS + TAG_BITS;
  localparam logic [SLOT_W:0] QD_EXT = (SLOT_W + 1)'(QUEUE_DEPTH);

  function automatic logic [SLOT_W-1:0] wrap_pos(input logic [SLOT_W-1:0] base,
                                                 input logic [SLOT_W-1:0] off);
    logic [SLOT_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= QD_EXT) begin
      sum = sum - QD_EXT;
    end
    return sum[SLOT_W-1:0];
  endfunction

  // request registers
  logic [TIME_BITS-1:0]  now_q, now_d;
  logic [TIME_BITS-1:0]  dl_q, dl_d;
  logic [TAG_BITS-1:0]   tag_q, tag_d;
  logic [CSLOT_BITS-1:0] cs_q, cs_d;

  // walk and queue registers
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [SLOT_W-1:0]     k_q, k_d;
  logic [SLOT_W-1:0]     j_q, j_d;
  logic [SLOT_W-1:0]     ins_q, ins_d;
  logic [SLOT_W-1:0]     t_q, t_d;
  logic [SLOT_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [QUEUE_DEPTH-1:0] in_use_q, in_use_d;
  logic [QUEUE_DEPTH-1:0] del_q, del_d;
  logic [NRES_W-1:0]     n_q, n_d;

  // pending fired result and output register
  logic                  pend_valid_q, pend_valid_d;
  logic [SLOT_W-1:0]     pend_slot_q, pend_slot_d;
  logic [TAG_BITS-1:0]   pend_tag_q, pend_tag_d;
  logic [LATE_BITS-1:0]  pend_late_q, pend_late_d;
  logic                  out_valid_q, out_valid_d;
  satq_res_t             out_q, out_d;

  // memory ports
  logic                  ord_we, ord_re, dl_we, dl_re;
  logic [SLOT_W-1:0]     ord_waddr, ord_raddr, ord_wdata, ord_rdata;
  logic [SLOT_W-1:0]     dl_waddr, dl_raddr;
  logic [DL_W-1:0]       dl_wdata, dl_rdata;

  logic [TIME_BITS-1:0]  rd_deadline;
  logic [TAG_BITS-1:0]   rd_tag;
  logic [TIME_BITS:0]    dl_sum;
  logic [TIME_BITS-1:0]  delay_ext;
  logic [TIME_BITS-1:0]  late_diff;
  logic [LATE_BITS-1:0]  late_sat;
  logic                  out_free;
  logic                  walk_move;
  logic                  head_due;

  satq_ram #(.WIDTH(SLOT_W), .DEPTH(QUEUE_DEPTH)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .re_i    (ord_re),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  satq_ram #(.WIDTH(DL_W), .DEPTH(QUEUE_DEPTH)) u_dl_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (dl_waddr),
    .wdata_i (dl_wdata),
    .re_i    (dl_re),
    .raddr_i (dl_raddr),
    .rdata_o (dl_rdata)
  );

  assign rd_deadline = dl_rdata[TAG_BITS +: TIME_BITS];
  assign rd_tag      = dl_rdata[TAG_BITS-1:0];

  // negative delay clamps to zero, overflow saturates
  assign delay_ext = in_req_i.offset_ms[DELAY_BITS-1] ? '0
                   : TIME_BITS'(unsigned'(in_req_i.offset_ms));
  assign dl_sum    = {1'b0, in_req_i.now_ms} + {1'b0, delay_ext};

  assign late_diff = now_q - rd_deadline;
  assign late_sat  = (|late_diff[TIME_BITS-1:LATE_BITS]) ? '1 : late_diff[LATE_BITS-1:0];

  assign out_free  = !out_valid_q || !out_stall_i;
  assign walk_move = (dl_q <= rd_deadline);
  assign head_due  = (now_q >= rd_deadline);

  always_comb begin
    now_d        = now_q;
    dl_d         = dl_q;
    tag_d        = tag_q;
    cs_d         = cs_q;
    slot_d       = slot_q;
    k_d          = k_q;
    j_d          = j_q;
    ins_d        = ins_q;
    t_d          = t_q;
    head_d       = head_q;
    count_d      = count_q;
    in_use_d     = in_use_q;
    del_d        = del_q;
    n_d          = n_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    pend_tag_d   = pend_tag_q;
    pend_late_d  = pend_late_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    ord_we       = 1'b0;
    ord_waddr    = '0;
    ord_wdata    = '0;
    ord_re       = 1'b0;
    ord_raddr    = '0;
    dl_we        = 1'b0;
    dl_waddr     = '0;
    dl_wdata     = '0;
    dl_re        = 1'b0;
    dl_raddr     = '0;

    case (cmd_i.op)
      OP_LOAD: begin
        now_d        = in_req_i.now_ms;
        dl_d         = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];
        tag_d        = in_req_i.tag;
        cs_d         = in_req_i.cancel_slot;
        k_d          = '0;
        n_d          = '0;
        pend_valid_d = 1'b0;
      end
      OP_FREE_STEP: begin
        if (!in_use_q[k_q]) begin
          slot_d = k_q;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      OP_WALK_INIT: begin
        ins_d = '0;
        j_d   = SLOT_W'(count_q - 1'b1);
      end
      OP_ORD_READ: begin
        ord_re    = 1'b1;
        ord_raddr = wrap_pos(head_q, j_q);
      end
      OP_DL_READ: begin
        dl_re    = 1'b1;
        dl_raddr = ord_rdata;
        t_d      = ord_rdata;
      end
      OP_WALK_CMP: begin
        if (walk_move) begin
          // later or equal deadline moves one place toward the tail
          ord_we    = 1'b1;
          ord_waddr = wrap_pos(head_q, j_q + 1'b1);
          ord_wdata = t_q;
          if (j_q == '0) begin
            ins_d = '0;
          end else begin
            j_d = j_q - 1'b1;
          end
        end else begin
          ins_d = j_q + 1'b1;
        end
      end
      OP_PLACE: begin
        ord_we           = 1'b1;
        ord_waddr        = wrap_pos(head_q, ins_q);
        ord_wdata        = slot_q;
        dl_we            = 1'b1;
        dl_waddr         = slot_q;
        dl_wdata         = {dl_q, tag_q};
        in_use_d[slot_q] = 1'b1;
        del_d[slot_q]    = 1'b0;
        count_d          = count_q + 1'b1;
      end
      OP_CANCEL: begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if ((int'(cs_q) == i) && in_use_q[i]) begin
            del_d[i] = 1'b1;
          end
        end
      end
      OP_HEAD_READ: begin
        ord_re    = 1'b1;
        ord_raddr = head_q;
      end
      OP_TICK_EVAL: begin
        if (del_q[t_q] || (head_due && (!pend_valid_q || out_free))) begin
          in_use_d[t_q] = 1'b0;
          del_d[t_q]    = 1'b0;
          head_d        = wrap_pos(head_q, SLOT_W'(1));
          count_d       = count_q - 1'b1;
        end
        if (!del_q[t_q] && head_due && (!pend_valid_q || out_free)) begin
          if (pend_valid_q) begin
            out_valid_d       = 1'b1;
            out_d.kind        = KIND_FIRED;
            out_d.slot        = SLOT_OUT_W'(pend_slot_q);
            out_d.fired_tag   = pend_tag_q;
            out_d.lateness_ms = pend_late_q;
            out_d.last        = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_slot_d  = t_q;
          pend_tag_d   = rd_tag;
          pend_late_d  = late_sat;
          n_d          = n_q + 1'b1;
        end
      end
      OP_EMIT: begin
        out_valid_d       = 1'b1;
        out_d.slot        = '0;
        out_d.fired_tag   = '0;
        out_d.lateness_ms = '0;
        out_d.last        = 1'b1;
        case (cmd_i.sel)
          SEL_ADDED: begin
            out_d.kind = KIND_ADDED;
            out_d.slot = SLOT_OUT_W'(slot_q);
          end
          SEL_FULL: begin
            out_d.kind = KIND_FULL;
          end
          SEL_CANCEL: begin
            out_d.kind = KIND_CANCEL;
            out_d.slot = cs_q;
          end
          SEL_TICK_END: begin
            if (pend_valid_q) begin
              out_d.kind        = KIND_FIRED;
              out_d.slot        = SLOT_OUT_W'(pend_slot_q);
              out_d.fired_tag   = pend_tag_q;
              out_d.lateness_ms = pend_late_q;
            end else begin
              out_d.kind = KIND_NONE;
            end
          end
          default: out_d.kind = KIND_NONE;
        endcase
        pend_valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      count_q      <= '0;
      in_use_q     <= '0;
      del_q        <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      head_q       <= head_d;
      count_q      <= count_d;
      in_use_q     <= in_use_d;
      del_q        <= del_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q       <= now_d;
    dl_q        <= dl_d;
    tag_q       <= tag_d;
    cs_q        <= cs_d;
    slot_q      <= slot_d;
    k_q         <= k_d;
    j_q         <= j_d;
    ins_q       <= ins_d;
    t_q         <= t_d;
    pend_slot_q <= pend_slot_d;
    pend_tag_q  <= pend_tag_d;
    pend_late_q <= pend_late_d;
    out_q       <= out_d;
  end

  assign status_o.full       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign status_o.empty      = (count_q == '0);
  assign status_o.free_hit   = !in_use_q[k_q];
  assign status_o.walk_move  = walk_move;
  assign status_o.walk_first = (j_q == '0);
  assign status_o.res_limit  = (n_q == NRES_W'(MAX_RESULTS));
  assign status_o.head_del   = del_q[t_q];
  assign status_o.head_due   = head_due;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

// ----- src/sorted_alarm_timer_queue.sv -----
// Top level of the sorted alarm timer queue: controller plus datapath.
//
// Requests enter on in_valid_i/in_stall_o with in_req_i: add an alarm,
// tick at the current time, or cancel a slot. Results leave on
// out_valid_o/out_stall_i with out_res_o; the final result of each request
// carries last. One request is worked on at a time; in_stall_o is high
// from the accepting edge until its last result is loaded.
// Steps per request, up to the result register being loaded: a cancel marks
// its slot for deletion if that slot is in use; an add to a full queue goes
// straight to its result; any other add scans for the lowest free slot, then
// walks from the tail of the order list, moving each later or equal deadline
// one place toward the tail until the first earlier one or the head, and then
// places the entry; a tick visits entries from the head (fired, dropped, or the
// first one not yet due), and its walk also ends on an empty queue or the
// result limit.
// Each step of a walk is one read of the order RAM then one of the slot RAM.
// A request type of 3 gives no result.
// Reset empties the queue; no clearing pass is needed. While the receiver
// stalls, the result holds and the block waits before loading the next one.
module sorted_alarm_timer_queue #(
  parameter int unsigned QUEUE_DEPTH = satq_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  satq_pkg::satq_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output satq_pkg::satq_res_t out_res_o
);
  import satq_pkg::*;

  satq_cmd_t    cmd;
  satq_status_t status;

  satq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_req_i.req_type),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  satq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o)
  );

endmodule

// ----- sim/sorted_alarm_timer_queue_test.sv -----
// Self-checking testbench for the sorted alarm timer queue: scoreboard, driver, monitor.
module sorted_alarm_timer_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import satq_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [LATE_BITS-1:0] LATE_MAX = '1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    satq_req_t req;
    logic      drain_first;
  } staged_request_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  satq_req_t in_req_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  satq_res_t out_res_o;

  staged_request_t pending_requests[$];
  satq_res_t       awaited_results[$];
  int              fail_count = 0;
  int              cycle_count = 0;
  int              requests_taken = 0;

  // scoreboard copy of the alarm store
  logic [TIME_BITS-1:0] alarm_due[QUEUE_DEPTH];
  logic [TAG_BITS-1:0]  alarm_tag[QUEUE_DEPTH];
  logic                 alarm_killed[QUEUE_DEPTH] = '{default: 1'b0};
  logic                 alarm_busy[QUEUE_DEPTH] = '{default: 1'b0};
  int                   due_order[QUEUE_DEPTH];
  int                   alarm_count = 0;

  sorted_alarm_timer_queue DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  function automatic void retire_head_alarm();
    int head;
    head = due_order[0];
    alarm_busy[head] = 1'b0;
    alarm_killed[head] = 1'b0;
    for (int i = 1; i < alarm_count; i++) due_order[i-1] = due_order[i];
    alarm_count--;
  endfunction

  function automatic void predict_timer_results(input satq_req_t r);
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] due;
    logic [TIME_BITS-1:0] late_wide;
    logic [31:0]          delay_pos;
    int                   free_slot;
    int                   pos;
    int                   head;
    satq_res_t            res;
    satq_res_t            burst[$];
    res = '0;
    res.last = 1'b1;
    case (r.req_type)
      REQ_ADD: begin
        if (alarm_count >= QUEUE_DEPTH) begin
          res.kind = KIND_FULL;
          awaited_results.push_back(res);
        end else begin
          delay_pos = r.offset_ms[DELAY_BITS-1] ? 32'd0 : r.offset_ms;
          sum = {1'b0, r.now_ms} + {{(TIME_BITS + 1 - 32){1'b0}}, delay_pos};
          due = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
          free_slot = -1;
          for (int s = QUEUE_DEPTH - 1; s >= 0; s--) if (!alarm_busy[s]) free_slot = s;
          pos = alarm_count;
          for (int i = alarm_count - 1; i >= 0; i--)
            if (due <= alarm_due[due_order[i]]) pos = i;
          for (int i = alarm_count; i > pos; i--) due_order[i] = due_order[i-1];
          due_order[pos] = free_slot;
          alarm_count++;
          alarm_busy[free_slot] = 1'b1;
          alarm_killed[free_slot] = 1'b0;
          alarm_due[free_slot] = due;
          alarm_tag[free_slot] = r.tag;
          res.kind = KIND_ADDED;
          res.slot = free_slot[SLOT_OUT_W-1:0];
          awaited_results.push_back(res);
        end
      end
      REQ_TICK: begin
        while (alarm_count > 0 && burst.size() < MAX_RESULTS) begin
          head = due_order[0];
          if (alarm_killed[head]) begin
            retire_head_alarm();
            continue;
          end
          if (r.now_ms < alarm_due[head]) break;
          late_wide = r.now_ms - alarm_due[head];
          res = '0;
          res.kind = KIND_FIRED;
          res.slot = head[SLOT_OUT_W-1:0];
          res.fired_tag = alarm_tag[head];
          res.lateness_ms = (late_wide > LATE_MAX) ? LATE_MAX : late_wide[LATE_BITS-1:0];
          burst.push_back(res);
          retire_head_alarm();
        end
        if (burst.size() == 0) begin
          res = '0;
          res.kind = KIND_NONE;
          res.last = 1'b1;
          burst.push_back(res);
        end
        burst[burst.size()-1].last = 1'b1;
        foreach (burst[i]) awaited_results.push_back(burst[i]);
      end
      REQ_CANCEL: begin
        if (alarm_busy[r.cancel_slot]) alarm_killed[r.cancel_slot] = 1'b1;
        res.kind = KIND_CANCEL;
        res.slot = r.cancel_slot;
        awaited_results.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // sender: bursts of requests with random gaps
  int burst_left = 0;
  int gap_left = 0;
  staged_request_t next_request;
  logic offer_next;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i <= '0;
      requests_taken <= 0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      offer_next = !in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        predict_timer_results(in_req_i);
        requests_taken <= requests_taken + 1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        offer_next = 1'b1;
      end
      if (offer_next) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() > 0 &&
                     (!pending_requests[0].drain_first || awaited_results.size() == 0)) begin
          next_request = pending_requests.pop_front();
          in_valid_i <= 1'b1;
          in_req_i <= next_request.req;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: randomly chosen stall styles in turn, plus one long hold once 60 requests are taken
  int   stall_style = 0;
  int   style_left = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic stall_phase = 1'b0;
  logic stall_next;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      style_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (!hold_done && requests_taken >= 60) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left = $urandom_range(32, 96);
      end
      style_left--;
      stall_phase = !stall_phase;
      case (stall_style)
        0: stall_next = 1'b0;
        1: stall_next = ($urandom_range(0, 3) == 0);
        2: stall_next = stall_phase;
        default: stall_next = ($urandom_range(0, 3) != 0);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end
      out_stall_i <= stall_next;
    end
  end

  satq_res_t head_result;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d slot=%0d tag=%h late=%0d last=%b", $time,
                 out_res_o.kind, out_res_o.slot, out_res_o.fired_tag, out_res_o.lateness_ms,
                 out_res_o.last);
        fail_count++;
      end else begin
        head_result = awaited_results.pop_front();
        if (out_res_o !== head_result) begin
          $display("%0t: mismatch expected kind=%0d slot=%0d tag=%h late=%0d last=%b", $time,
                   head_result.kind, head_result.slot, head_result.fired_tag,
                   head_result.lateness_ms, head_result.last);
          $display("%0t:          actual   kind=%0d slot=%0d tag=%h late=%0d last=%b", $time,
                   out_res_o.kind, out_res_o.slot, out_res_o.fired_tag,
                   out_res_o.lateness_ms, out_res_o.last);
          fail_count++;
        end
      end
    end
  end

  function automatic void stage_request(input logic [1:0] kind, input logic [TIME_BITS-1:0] now,
                                        input logic [31:0] delay, input logic [TAG_BITS-1:0] tag,
                                        input logic [CSLOT_BITS-1:0] cslot, input logic drain);
    staged_request_t item;
    item.req.req_type = kind;
    item.req.now_ms = now;
    item.req.offset_ms = delay;
    item.req.tag = tag;
    item.req.cancel_slot = cslot;
    item.drain_first = drain;
    pending_requests.push_back(item);
  endfunction

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout", $time);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [TIME_BITS-1:0] clock_ms;
    logic [31:0]          delay;
    int                   roll;
    int                   add_edge;
    int                   tick_edge;
    logic                 drain;

    // directed: empty tick, extreme delays, equal deadlines, saturation, full, cancels
    stage_request(REQ_TICK, '0, $urandom, TAG_BITS'($urandom), CSLOT_BITS'($urandom), 1'b0);
    stage_request(REQ_ADD, '0, 32'h8000_0000, 16'hFFFF, CSLOT_BITS'($urandom), 1'b0);
    stage_request(REQ_ADD, '0, 32'h7FFF_FFFF, 16'h0000, CSLOT_BITS'($urandom), 1'b0);
    stage_request(REQ_ADD, 48'd10, 32'd5, TAG_BITS'($urandom), CSLOT_BITS'($urandom), 1'b0);
    stage_request(REQ_ADD, 48'd5, 32'd10, TAG_BITS'($urandom), CSLOT_BITS'($urandom), 1'b0);
    stage_request(REQ_ADD, TIME_MAX, 32'h7FFF_FFFF, TAG_BITS'($urandom),
                  CSLOT_BITS'($urandom), 1'b0);
    for (int i = 0; i < 11; i++)
      stage_request(REQ_ADD, 48'd100, $urandom_range(0, 50), TAG_BITS'($urandom),
                    CSLOT_BITS'($urandom), 1'b0);
    stage_request(REQ_CANCEL, TIME_BITS'($urandom), $urandom, TAG_BITS'($urandom), 4'd2, 1'b0);
    stage_request(REQ_CANCEL, TIME_BITS'($urandom), $urandom, TAG_BITS'($urandom), 4'd2, 1'b0);
    stage_request(REQ_ADD, 48'd200, 32'd0, TAG_BITS'($urandom), CSLOT_BITS'($urandom), 1'b0);
    stage_request(REQ_UNUSED, TIME_BITS'($urandom), $urandom, TAG_BITS'($urandom),
                  CSLOT_BITS'($urandom), 1'b0);
    stage_request(REQ_TICK, 48'd20, $urandom, TAG_BITS'($urandom), CSLOT_BITS'($urandom), 1'b0);
    stage_request(REQ_TICK, TIME_MAX, $urandom, TAG_BITS'($urandom), CSLOT_BITS'($urandom),
                  1'b0);
    stage_request(REQ_CANCEL, TIME_BITS'($urandom), $urandom, TAG_BITS'($urandom), 4'd15, 1'b0);

    // random: alternating add-heavy and tick-heavy phases on a mostly advancing clock
    clock_ms = TIME_BITS'($urandom_range(0, 1000));
    for (int i = 0; i < 80; i++) begin
      add_edge = ((i / 20) % 2 == 0) ? 65 : 30;
      tick_edge = ((i / 20) % 2 == 0) ? 85 : 80;
      drain = (i == 0) || ($urandom_range(0, 19) == 0);
      if ($urandom_range(0, 29) == 0) clock_ms = TIME_BITS'({$urandom, $urandom});
      roll = $urandom_range(0, 99);
      if (roll < add_edge) begin
        case ($urandom_range(0, 9))
          0: delay = $urandom | 32'h8000_0000;
          1: delay = $urandom;
          default: delay = $urandom_range(0, 400);
        endcase
        stage_request(REQ_ADD, clock_ms, delay, TAG_BITS'($urandom), CSLOT_BITS'($urandom),
                      drain);
      end else if (roll < tick_edge) begin
        clock_ms = clock_ms + TIME_BITS'($urandom_range(0, 250));
        stage_request(REQ_TICK, clock_ms, $urandom, TAG_BITS'($urandom), CSLOT_BITS'($urandom),
                      drain);
      end else if (roll < 97) begin
        stage_request(REQ_CANCEL, clock_ms, $urandom, TAG_BITS'($urandom),
                      CSLOT_BITS'($urandom_range(0, 15)), drain);
      end else begin
        stage_request(REQ_UNUSED, clock_ms, $urandom, TAG_BITS'($urandom),
                      CSLOT_BITS'($urandom), drain);
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || in_valid_i || awaited_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (awaited_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
